### rtl/core/dqv_pkg.sv
// ----------------------------------------------------------------------------
// dqv_pkg
// Types, constants and helper functions shared by the query validator modules.
// ----------------------------------------------------------------------------
package dqv_pkg;

  localparam int unsigned HDR_BYTES = 12;
  localparam int unsigned MIN_BYTES = 17;
  localparam logic [7:0]  MAX_LABEL = 8'd63;
  localparam logic [11:0] NAME_MAX  = 12'hFFF;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  localparam logic [15:0] T_A     = 16'd1;
  localparam logic [15:0] T_NS    = 16'd2;
  localparam logic [15:0] T_CNAME = 16'd5;
  localparam logic [15:0] T_SOA   = 16'd6;
  localparam logic [15:0] T_PTR   = 16'd12;
  localparam logic [15:0] T_MX    = 16'd15;
  localparam logic [15:0] T_TXT   = 16'd16;
  localparam logic [15:0] T_AAAA  = 16'd28;
  localparam logic [15:0] T_SRV   = 16'd33;

  typedef enum logic [1:0] {
    VERDICT_OK     = 2'd0,
    VERDICT_IGNORE = 2'd1,
    VERDICT_NOTIMP = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    PH_LEN   = 3'b001,
    PH_LABEL = 3'b010,
    PH_DONE  = 3'b100
  } phase_t;

  typedef struct packed {
    logic        len_bad;
    logic        hdr_bad;
    logic        name_good;
    logic        tail_good;
    logic        rd;
    logic [15:0] tid;
    logic [15:0] arcount;
    logic [31:0] tc_bytes;
    logic [11:0] name_bytes;
  } rec_t;

  function automatic logic char_ok(input logic [7:0] c);
    logic ok;
    ok = (c == CH_STAR) || (c == CH_DASH) || (c == CH_UNDER) ||
         ((c >= CH_ZERO) && (c <= CH_NINE)) ||
         ((c >= CH_UA) && (c <= CH_UZ)) ||
         ((c >= CH_LA) && (c <= CH_LZ));
    return ok;
  endfunction

  function automatic logic type_supported(input logic [15:0] t);
    logic ok;
    ok = (t == T_A) || (t == T_NS) || (t == T_CNAME) || (t == T_SOA) ||
         (t == T_PTR) || (t == T_MX) || (t == T_TXT) || (t == T_AAAA) ||
         (t == T_SRV);
    return ok;
  endfunction

endpackage

### rtl/core/dqv_front.sv
// ----------------------------------------------------------------------------
// dqv_front
// Byte parser: captures the header, walks the question name and the type and
// class bytes, and emits one summary record per packet on its final byte.
// ----------------------------------------------------------------------------
module dqv_front import dqv_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] pkt_byte,
  input  logic       last,
  output logic       rec_valid,
  output rec_t       rec
);

  localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 2);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES);
  localparam logic [POS_W-1:0] POS_LIM = POS_W'(MAX_PACKET_BYTES + 1);
  localparam logic [POS_W-1:0] POS_HDR = POS_W'(HDR_BYTES);
  localparam logic [POS_W-1:0] POS_MIN = POS_W'(MIN_BYTES);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      hw0_r, hw1_r, hw2_r, hw3_r, hw4_r, hw5_r;
  logic [15:0]      hw0_nxt, hw1_nxt, hw2_nxt, hw3_nxt, hw4_nxt, hw5_nxt;
  logic [5:0]       rem_r, rem_nxt, rem_dec;
  phase_t           phase_r, phase_nxt;
  logic [11:0]      nbytes_r, nbytes_nxt;
  logic             bad_r, bad_nxt;
  logic [31:0]      tc_r, tc_nxt;
  logic [2:0]       tail_r, tail_nxt;

  always_comb begin
    pos_nxt    = pos_r;
    hw0_nxt    = hw0_r;
    hw1_nxt    = hw1_r;
    hw2_nxt    = hw2_r;
    hw3_nxt    = hw3_r;
    hw4_nxt    = hw4_r;
    hw5_nxt    = hw5_r;
    rem_nxt    = rem_r;
    phase_nxt  = phase_r;
    nbytes_nxt = nbytes_r;
    bad_nxt    = bad_r;
    tc_nxt     = tc_r;
    tail_nxt   = tail_r;
    rem_dec    = (rem_r != 6'd0) ? rem_r - 6'd1 : 6'd0;
    if (accept && (pos_r < POS_MAX)) begin
      if (pos_r < POS_HDR) begin
        case (pos_r[3:1])
          3'd0: hw0_nxt = {hw0_r[7:0], pkt_byte};
          3'd1: hw1_nxt = {hw1_r[7:0], pkt_byte};
          3'd2: hw2_nxt = {hw2_r[7:0], pkt_byte};
          3'd3: hw3_nxt = {hw3_r[7:0], pkt_byte};
          3'd4: hw4_nxt = {hw4_r[7:0], pkt_byte};
          3'd5: hw5_nxt = {hw5_r[7:0], pkt_byte};
          default: hw0_nxt = hw0_r;
        endcase
      end else if (!bad_r) begin
        case (phase_r)
          PH_LEN: begin
            if (nbytes_r == NAME_MAX) bad_nxt = 1'b1;
            else nbytes_nxt = nbytes_r + 12'd1;
            if (pkt_byte == 8'd0) begin
              phase_nxt = PH_DONE;
            end else if (pkt_byte > MAX_LABEL) begin
              bad_nxt = 1'b1;
            end else begin
              rem_nxt   = pkt_byte[5:0];
              phase_nxt = PH_LABEL;
            end
          end
          PH_LABEL: begin
            if (nbytes_r == NAME_MAX) bad_nxt = 1'b1;
            else nbytes_nxt = nbytes_r + 12'd1;
            if (!char_ok(pkt_byte)) bad_nxt = 1'b1;
            rem_nxt = rem_dec;
            if (rem_dec == 6'd0) phase_nxt = PH_LEN;
          end
          PH_DONE: begin
            if (tail_r < 3'd4) begin
              tc_nxt   = {tc_r[23:0], pkt_byte};
              tail_nxt = tail_r + 3'd1;
            end
          end
          default: phase_nxt = PH_LEN;
        endcase
      end
    end
    if (accept && (pos_r < POS_LIM)) pos_nxt = pos_r + POS_W'(1);
  end

  always_comb begin
    rec_valid      = accept && last;
    rec.len_bad    = (pos_nxt < POS_MIN) || (pos_nxt > POS_MAX);
    rec.hdr_bad    = (hw2_nxt != 16'd1) || (hw3_nxt != 16'd0) || (hw4_nxt != 16'd0) ||
                     hw1_nxt[15] || hw1_nxt[9];
    rec.name_good  = !bad_nxt && (phase_nxt == PH_DONE);
    rec.tail_good  = !bad_nxt && (phase_nxt == PH_DONE) && (tail_nxt == 3'd4);
    rec.rd         = hw1_nxt[8];
    rec.tid        = hw0_nxt;
    rec.arcount    = hw5_nxt;
    rec.tc_bytes   = tc_nxt;
    rec.name_bytes = nbytes_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last)) begin
      pos_r    <= '0;
      hw0_r    <= '0;
      hw1_r    <= '0;
      hw2_r    <= '0;
      hw3_r    <= '0;
      hw4_r    <= '0;
      hw5_r    <= '0;
      rem_r    <= '0;
      phase_r  <= PH_LEN;
      nbytes_r <= '0;
      bad_r    <= 1'b0;
      tc_r     <= '0;
      tail_r   <= '0;
    end else begin
      pos_r    <= pos_nxt;
      hw0_r    <= hw0_nxt;
      hw1_r    <= hw1_nxt;
      hw2_r    <= hw2_nxt;
      hw3_r    <= hw3_nxt;
      hw4_r    <= hw4_nxt;
      hw5_r    <= hw5_nxt;
      rem_r    <= rem_nxt;
      phase_r  <= phase_nxt;
      nbytes_r <= nbytes_nxt;
      bad_r    <= bad_nxt;
      tc_r     <= tc_nxt;
      tail_r   <= tail_nxt;
    end
  end

endmodule

### rtl/core/dqv_fifo.sv
// ----------------------------------------------------------------------------
// dqv_fifo
// Two-entry queue of packet summary records between parser and verdict stage.
// ----------------------------------------------------------------------------
module dqv_fifo import dqv_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  rec_t wr_rec,
  input  logic rd_en,
  output logic full,
  output logic nonempty,
  output rec_t rd_rec
);

  rec_t                 mem_r [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]      cnt_r, cnt_nxt;
  logic                 do_wr, do_rd;

  assign full     = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign nonempty = (cnt_r != '0);
  assign rd_rec   = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && nonempty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    else if (!do_wr && do_rd) cnt_nxt = cnt_r - (QPTR_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_rd) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/core/dqv_back.sv
// ----------------------------------------------------------------------------
// dqv_back
// Verdict stage: turns a summary record into the result fields and holds
// them in the output register until popped.
// ----------------------------------------------------------------------------
module dqv_back import dqv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        rec_avail,
  input  rec_t        rec,
  output logic        rec_take,
  input  logic        pop,
  output logic        empty,
  output logic [1:0]  verdict,
  output logic [15:0] transaction_id,
  output logic        recursion_desired,
  output logic [15:0] query_type,
  output logic [15:0] query_class,
  output logic [11:0] name_length,
  output logic [15:0] additional_count,
  output logic [11:0] question_end
);

  logic        valid_r;
  verdict_t    verdict_r, verdict_nxt;
  logic [15:0] tid_r, qtype_r, qclass_r, arcount_r;
  logic [15:0] qtype_nxt, qclass_nxt;
  logic        rd_r;
  logic [11:0] nlen_r, qend_r, nlen_nxt, qend_nxt;
  logic [12:0] qend_sum;

  assign rec_take = rec_avail && (!valid_r || pop);
  assign empty    = !valid_r;

  always_comb begin
    qtype_nxt  = rec.tail_good ? rec.tc_bytes[31:16] : 16'd0;
    qclass_nxt = rec.tail_good ? rec.tc_bytes[15:0] : 16'd0;
    nlen_nxt   = rec.name_good ? rec.name_bytes : 12'd0;
    qend_sum   = {1'b0, nlen_nxt} + 13'(HDR_BYTES + 4);
    qend_nxt   = 12'd0;
    if (rec.tail_good) qend_nxt = qend_sum[12] ? NAME_MAX : qend_sum[11:0];
    if (rec.len_bad || rec.hdr_bad || !rec.tail_good) verdict_nxt = VERDICT_IGNORE;
    else if (!type_supported(qtype_nxt)) verdict_nxt = VERDICT_NOTIMP;
    else verdict_nxt = VERDICT_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (rec_take) begin
      valid_r <= 1'b1;
    end else if (pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_take) begin
      verdict_r <= verdict_nxt;
      tid_r     <= rec.tid;
      rd_r      <= rec.rd;
      qtype_r   <= qtype_nxt;
      qclass_r  <= qclass_nxt;
      nlen_r    <= nlen_nxt;
      arcount_r <= rec.arcount;
      qend_r    <= qend_nxt;
    end
  end

  assign verdict           = verdict_r;
  assign transaction_id    = tid_r;
  assign recursion_desired = rd_r;
  assign query_type        = qtype_r;
  assign query_class       = qclass_r;
  assign name_length       = nlen_r;
  assign additional_count  = arcount_r;
  assign question_end      = qend_r;

endmodule

### rtl/core/dns_query_validator.sv
// ----------------------------------------------------------------------------
// dns_query_validator
// DNS query header and question checker with queue-style ports.
// ----------------------------------------------------------------------------
// Packet bytes are taken one per cycle while full is low, with no gaps needed
// between packets. The record for a packet enters the parser-to-verdict record
// queue when its last byte is accepted, and it loads the output register once
// that register is empty or being popped. full rises only while the
// two-entry record queue is full, which happens when results are not popped
// for several packets.
// ----------------------------------------------------------------------------
module dns_query_validator import dqv_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_packet_byte,
  input  logic        in_last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_verdict,
  output logic [15:0] out_transaction_id,
  output logic        out_recursion_desired,
  output logic [15:0] out_query_type,
  output logic [15:0] out_query_class,
  output logic [11:0] out_name_length,
  output logic [15:0] out_additional_count,
  output logic [11:0] out_question_end
);

  logic accept;
  logic front_valid;
  rec_t front_rec;
  logic q_full, q_nonempty, q_take;
  rec_t q_rec;

  assign full   = q_full;
  assign accept = push && !q_full;

  dqv_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .pkt_byte (in_packet_byte),
    .last     (in_last_byte),
    .rec_valid(front_valid),
    .rec      (front_rec)
  );

  dqv_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (front_valid),
    .wr_rec  (front_rec),
    .rd_en   (q_take),
    .full    (q_full),
    .nonempty(q_nonempty),
    .rd_rec  (q_rec)
  );

  dqv_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .rec_avail        (q_nonempty),
    .rec              (q_rec),
    .rec_take         (q_take),
    .pop              (pop),
    .empty            (empty),
    .verdict          (out_verdict),
    .transaction_id   (out_transaction_id),
    .recursion_desired(out_recursion_desired),
    .query_type       (out_query_type),
    .query_class      (out_query_class),
    .name_length      (out_name_length),
    .additional_count (out_additional_count),
    .question_end     (out_question_end)
  );

endmodule

### sim/dns_query_validator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_query_validator_checker
// Watches both queue ports of the DNS query validator and checks each verdict.
// Every accepted request byte feeds a parser model of header, question name
// and qtype/qclass; a last byte closes the packet and queues the expected
// verdict record. Each popped result is compared field by field against the
// oldest queued record. The failure count and the number of records still
// awaited go to the testbench top.
// ----------------------------------------------------------------------------
module dns_query_validator_checker import dqv_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  in_packet_byte,
  input  logic        in_last_byte,
  input  logic        empty,
  input  logic        pop,
  input  logic [1:0]  out_verdict,
  input  logic [15:0] out_transaction_id,
  input  logic        out_recursion_desired,
  input  logic [15:0] out_query_type,
  input  logic [15:0] out_query_class,
  input  logic [11:0] out_name_length,
  input  logic [15:0] out_additional_count,
  input  logic [11:0] out_question_end,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    verdict_t    verdict;
    logic [15:0] tid;
    logic        rd;
    logic [15:0] qtype;
    logic [15:0] qclass;
    logic [11:0] name_len;
    logic [15:0] arcount;
    logic [11:0] qend;
  } query_verdict_t;

  query_verdict_t awaited_verdicts[$];
  int             errors;

  int unsigned    pkt_pos;
  logic [15:0]    hdr [6];
  int unsigned    label_left;
  phase_t         phase;
  int unsigned    enc_len;
  logic           name_broken;
  logic [31:0]    tail_shift;
  int unsigned    tail_seen;

  function automatic logic label_char_legal(input logic [7:0] c);
    if (c == CH_STAR || c == CH_DASH || c == CH_UNDER) return 1'b1;
    if (c >= 8'h30 && c <= 8'h39) return 1'b1;
    if (c >= 8'h41 && c <= 8'h5A) return 1'b1;
    return c >= 8'h61 && c <= 8'h7A;
  endfunction

  function automatic logic qtype_known(input logic [15:0] t);
    case (t)
      T_A, T_NS, T_CNAME, T_SOA, T_PTR, T_MX, T_TXT, T_AAAA, T_SRV: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void clear_parser();
    pkt_pos = 0;
    foreach (hdr[i]) hdr[i] = '0;
    label_left = 0;
    phase = PH_LEN;
    enc_len = 0;
    name_broken = 1'b0;
    tail_shift = '0;
    tail_seen = 0;
  endfunction

  function automatic void bump_name_length();
    if (enc_len >= 4095) name_broken = 1'b1;
    else enc_len++;
  endfunction

  task automatic absorb_byte(input logic [7:0] b, input logic last);
    query_verdict_t r;
    logic           name_good;
    logic           tail_good;
    logic [15:0]    flags;
    int unsigned    qend;
    if (pkt_pos < MAX_PACKET_BYTES) begin
      if (pkt_pos < HDR_BYTES) begin
        hdr[pkt_pos >> 1] = {hdr[pkt_pos >> 1][7:0], b};
      end else if (!name_broken) begin
        case (phase)
          PH_LEN: begin
            bump_name_length();
            if (b == 8'd0) phase = PH_DONE;
            else if (b > MAX_LABEL) name_broken = 1'b1;
            else begin
              label_left = b;
              phase = PH_LABEL;
            end
          end
          PH_LABEL: begin
            bump_name_length();
            if (!label_char_legal(b)) name_broken = 1'b1;
            if (label_left > 0) label_left--;
            if (label_left == 0) phase = PH_LEN;
          end
          default: begin
            if (tail_seen < 4) begin
              tail_shift = {tail_shift[23:0], b};
              tail_seen++;
            end
          end
        endcase
      end
    end
    if (pkt_pos <= MAX_PACKET_BYTES) pkt_pos++;
    if (last) begin
      flags = hdr[1];
      name_good = !name_broken && phase == PH_DONE;
      tail_good = name_good && tail_seen == 4;
      r.tid = hdr[0];
      r.rd = flags[8];
      r.qtype = tail_good ? tail_shift[31:16] : 16'd0;
      r.qclass = tail_good ? tail_shift[15:0] : 16'd0;
      r.name_len = name_good ? 12'(enc_len) : 12'd0;
      r.arcount = hdr[5];
      qend = tail_good ? HDR_BYTES + enc_len + 4 : 0;
      r.qend = (qend > 4095) ? 12'hFFF : 12'(qend);
      if (pkt_pos < MIN_BYTES || pkt_pos > MAX_PACKET_BYTES || !tail_good ||
          hdr[2] != 16'd1 || hdr[3] != 16'd0 || hdr[4] != 16'd0 || flags[15] || flags[9])
        r.verdict = VERDICT_IGNORE;
      else if (!qtype_known(r.qtype))
        r.verdict = VERDICT_NOTIMP;
      else
        r.verdict = VERDICT_OK;
      awaited_verdicts.push_back(r);
      clear_parser();
    end
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    query_verdict_t w;
    if (rst_n !== 1'b1) begin
      clear_parser();
      awaited_verdicts.delete();
      errors = 0;
    end else begin
      if (pop && !empty) begin
        if (awaited_verdicts.size() == 0) begin
          $error("result with no request packet outstanding: verdict %0d", out_verdict);
          errors++;
        end else begin
          w = awaited_verdicts.pop_front();
          check_field("verdict", 16'(w.verdict), 16'(out_verdict));
          check_field("transaction_id", w.tid, out_transaction_id);
          check_field("recursion_desired", 16'(w.rd), 16'(out_recursion_desired));
          check_field("query_type", w.qtype, out_query_type);
          check_field("query_class", w.qclass, out_query_class);
          check_field("name_length", 16'(w.name_len), 16'(out_name_length));
          check_field("additional_count", w.arcount, out_additional_count);
          check_field("question_end", 16'(w.qend), 16'(out_question_end));
        end
      end
      if (push && !full) absorb_byte(in_packet_byte, in_last_byte);
    end
    fail_count <= errors;
    pending <= awaited_verdicts.size();
  end

endmodule

### sim/dns_query_validator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_query_validator_test
// Testbench top for the DNS query validator.
// Sends DNS query packets byte by byte: a directed set covering header flag
// and count checks, every supported qtype, label length and character limits,
// short and truncated packets, then random mostly well-formed
// queries with noise and corrupted ones mixed in. Both ports idle at random,
// the result side holds off once long enough to back up the block, and a
// checker instance predicts and compares every verdict.
// ----------------------------------------------------------------------------
module dns_query_validator_test;
  import dqv_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_packet_byte;
  logic        in_last_byte;
  logic        empty;
  logic        pop;
  logic [1:0]  out_verdict;
  logic [15:0] out_transaction_id;
  logic        out_recursion_desired;
  logic [15:0] out_query_type;
  logic [15:0] out_query_class;
  logic [11:0] out_name_length;
  logic [15:0] out_additional_count;
  logic [11:0] out_question_end;

  int          fail_count;
  int          pending;
  int          stall_cycles;
  int          sent_bytes;
  int          send_idle_pct = 13;
  int          recv_idle_pct = 49;

  logic [7:0]  query_bytes[$];
  logic [15:0] known_types [9] = '{T_A, T_NS, T_CNAME, T_SOA, T_PTR, T_MX, T_TXT,
                                   T_AAAA, T_SRV};
  string       legal_chars =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_*";

  dns_query_validator i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .push                  (push),
    .full                  (full),
    .in_packet_byte        (in_packet_byte),
    .in_last_byte          (in_last_byte),
    .empty                 (empty),
    .pop                   (pop),
    .out_verdict           (out_verdict),
    .out_transaction_id    (out_transaction_id),
    .out_recursion_desired (out_recursion_desired),
    .out_query_type        (out_query_type),
    .out_query_class       (out_query_class),
    .out_name_length       (out_name_length),
    .out_additional_count  (out_additional_count),
    .out_question_end      (out_question_end)
  );

  dns_query_validator_checker i_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .push                  (push),
    .full                  (full),
    .in_packet_byte        (in_packet_byte),
    .in_last_byte          (in_last_byte),
    .empty                 (empty),
    .pop                   (pop),
    .out_verdict           (out_verdict),
    .out_transaction_id    (out_transaction_id),
    .out_recursion_desired (out_recursion_desired),
    .out_query_type        (out_query_type),
    .out_query_class       (out_query_class),
    .out_name_length       (out_name_length),
    .out_additional_count  (out_additional_count),
    .out_question_end      (out_question_end),
    .fail_count            (fail_count),
    .pending               (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic put_word(input logic [15:0] w);
    query_bytes.push_back(w[15:8]);
    query_bytes.push_back(w[7:0]);
  endtask

  task automatic put_header(input logic [15:0] tid, input logic [15:0] flags,
                            input logic [15:0] qd, input logic [15:0] an,
                            input logic [15:0] ns, input logic [15:0] ar);
    put_word(tid);
    put_word(flags);
    put_word(qd);
    put_word(an);
    put_word(ns);
    put_word(ar);
  endtask

  task automatic put_label(input int len);
    query_bytes.push_back(8'(len));
    repeat (len) query_bytes.push_back(legal_chars[$urandom_range(legal_chars.len() - 1)]);
  endtask

  task automatic put_name(input int labels);
    repeat (labels)
      put_label(($urandom_range(19) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 8));
    query_bytes.push_back(8'h00);
  endtask

  task automatic plain_query(input logic [15:0] flags, input logic [15:0] qd,
                             input logic [15:0] an, input logic [15:0] ns,
                             input logic [15:0] qtype);
    put_header(16'($urandom), flags, qd, an, ns, 16'($urandom_range(0, 3)));
    put_name($urandom_range(1, 2));
    put_word(qtype);
    put_word(16'h0001);
  endtask

  task automatic random_query();
    int          kind;
    int          cut;
    logic [15:0] flags;
    logic [15:0] qd;
    logic [15:0] an;
    logic [15:0] ns;
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 40)) query_bytes.push_back(8'($urandom));
      return;
    end
    flags = 16'($urandom);
    if (kind >= 16) flags = flags & 16'h7DFF;
    qd = 16'd1;
    an = 16'd0;
    ns = 16'd0;
    if (kind >= 16 && kind < 24) begin
      qd = 16'($urandom_range(0, 2));
      an = 16'($urandom_range(0, 1));
      ns = 16'($urandom_range(0, 1));
    end
    put_header(16'($urandom), flags, qd, an, ns,
               ($urandom_range(3) == 0) ? 16'($urandom) : 16'd0);
    put_name($urandom_range(0, 4));
    put_word(($urandom_range(3) == 0) ? 16'($urandom) : known_types[$urandom_range(8)]);
    put_word(($urandom_range(4) == 0) ? 16'($urandom) : 16'h0001);
    if (kind >= 24 && kind < 34)
      query_bytes[$urandom_range(12, query_bytes.size() - 5)] = 8'($urandom);
    if ($urandom_range(4) == 0)
      repeat ($urandom_range(1, 11)) query_bytes.push_back(8'($urandom));
    if (kind >= 34 && kind < 42) begin
      cut = $urandom_range(1, query_bytes.size() - 1);
      while (query_bytes.size() > cut) void'(query_bytes.pop_back());
    end
  endtask

  task automatic send_query();
    foreach (query_bytes[i]) begin
      while ($urandom_range(99) < send_idle_pct) begin
        push <= 1'b0;
        in_packet_byte <= 8'($urandom);
        in_last_byte <= 1'($urandom);
        @(posedge clk);
      end
      push <= 1'b1;
      in_packet_byte <= query_bytes[i];
      in_last_byte <= (i == query_bytes.size() - 1);
      do @(posedge clk); while (full);
    end
    sent_bytes += query_bytes.size();
    query_bytes.delete();
  endtask

  initial begin : stimulus
    logic [7:0]  bad_chars [9];
    string       border_chars;
    bad_chars = '{8'h00, 8'h2F, 8'h3A, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h80, 8'hFF};
    border_chars = "*-_09AZaz";
    sent_bytes = 0;
    rst_n <= 1'b0;
    push <= 1'b0;
    in_packet_byte <= 8'h00;
    in_last_byte <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // root name, shortest full packet
    put_header(16'h0000, 16'h0000, 16'd1, 16'd0, 16'd0, 16'd0);
    query_bytes.push_back(8'h00);
    put_word(T_A);
    put_word(16'h0000);
    send_query();
    foreach (known_types[i]) begin
      plain_query(16'h0100, 16'd1, 16'd0, 16'd0, known_types[i]);
      send_query();
    end
    plain_query(16'h0100, 16'd1, 16'd0, 16'd0, 16'h0000);
    send_query();
    plain_query(16'h0000, 16'd1, 16'd0, 16'd0, 16'hFFFF);
    send_query();
    put_header(16'hFFFF, 16'h7DFF, 16'd1, 16'd0, 16'd0, 16'hFFFF);
    put_name(3);
    put_word(T_AAAA);
    put_word(16'hFFFF);
    send_query();
    plain_query(16'h8000, 16'd1, 16'd0, 16'd0, T_A);
    send_query();
    plain_query(16'h0200, 16'd1, 16'd0, 16'd0, T_A);
    send_query();
    plain_query(16'h0100, 16'd0, 16'd0, 16'd0, T_A);
    send_query();
    plain_query(16'h0100, 16'd2, 16'd0, 16'd0, T_A);
    send_query();
    plain_query(16'h0100, 16'd1, 16'd1, 16'd0, T_A);
    send_query();
    plain_query(16'h0100, 16'd1, 16'd0, 16'd1, T_A);
    send_query();
    // longest legal label
    put_header(16'h1234, 16'h0100, 16'd1, 16'd0, 16'd0, 16'd0);
    put_label(63);
    query_bytes.push_back(8'h00);
    put_word(T_MX);
    put_word(16'h0001);
    send_query();
    foreach (bad_chars[i]) begin
      put_header(16'($urandom), 16'h0100, 16'd1, 16'd0, 16'd0, 16'd0);
      if (i < 2) query_bytes.push_back((i == 0) ? MAX_LABEL + 8'd1 : 8'hFF);
      else query_bytes.push_back(8'd3);
      query_bytes.push_back(8'h61);
      query_bytes.push_back(bad_chars[i]);
      query_bytes.push_back(8'h62);
      query_bytes.push_back(8'h00);
      put_word(T_A);
      put_word(16'h0001);
      send_query();
    end
    put_header(16'h0F0F, 16'h0100, 16'd1, 16'd0, 16'd0, 16'd0);
    query_bytes.push_back(8'(border_chars.len()));
    for (int k = 0; k < border_chars.len(); k++) query_bytes.push_back(border_chars[k]);
    query_bytes.push_back(8'h00);
    put_word(T_TXT);
    put_word(16'h0001);
    send_query();
    // one byte short of a full question
    put_header(16'h5555, 16'h0100, 16'd1, 16'd0, 16'd0, 16'd0);
    query_bytes.push_back(8'h00);
    put_word(T_A);
    query_bytes.push_back(8'h00);
    send_query();
    put_header(16'hAAAA, 16'h0100, 16'd1, 16'd0, 16'd0, 16'd0);
    put_label(5);
    send_query();
    query_bytes.push_back(8'hFF);
    send_query();
    repeat (6) query_bytes.push_back(8'($urandom));
    send_query();
    plain_query(16'h0100, 16'd1, 16'd0, 16'd0, T_SRV);
    repeat (11) query_bytes.push_back(8'($urandom));
    send_query();

    while (sent_bytes < 1950) begin
      if (sent_bytes >= 1300) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (sent_bytes >= 650) begin
        send_idle_pct = 49;
        recv_idle_pct = 13;
      end
      random_query();
      send_query();
    end

    push <= 1'b0;
    in_last_byte <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("[dns_query_validator] OK");
    else
      $display("[dns_query_validator] ERROR");
    $finish;
  end

  initial begin : drain
    int results_seen;
    int held;
    bit hold_done;
    results_seen = 0;
    hold_done = 1'b0;
    pop <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!hold_done && results_seen >= 50) begin
        // hold off so the record queue backs up and full rises
        pop <= 1'b0;
        for (held = 0; held < 400; held++) @(posedge clk);
        hold_done = 1'b1;
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
      @(posedge clk);
      if (pop && !empty) results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[dns_query_validator] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
